// ----- hdl/prs_pkg.sv -----
// Package: types and constants shared by the restart supervisor.
`timescale 1ns / 1ps
`default_nettype none

package prs_pkg;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_START   = 2'd1,
		OP_STOP    = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [5:0] {
		ST_STOPPED  = 6'b000001,
		ST_STARTING = 6'b000010,
		ST_RUNNING  = 6'b000100,
		ST_EXITED   = 6'b001000,
		ST_STOPPING = 6'b010000,
		ST_BACKOFF  = 6'b100000
	} state_t;

	localparam logic [2:0] LS_STOPPED  = 3'd0;
	localparam logic [2:0] LS_STARTING = 3'd1;
	localparam logic [2:0] LS_RUNNING  = 3'd2;
	localparam logic [2:0] LS_EXITED   = 3'd3;
	localparam logic [2:0] LS_STOPPING = 3'd4;
	localparam logic [2:0] LS_BACKOFF  = 3'd5;

	localparam logic [1:0] MODE_NEVER    = 2'd0;
	localparam logic [1:0] MODE_ALWAYS   = 2'd1;
	localparam logic [1:0] MODE_ON_ERROR = 2'd2;

	localparam logic [2:0] REG_START_WINDOW   = 3'd0;
	localparam logic [2:0] REG_STOP_WINDOW    = 3'd1;
	localparam logic [2:0] REG_RETRY_LIMIT    = 3'd2;
	localparam logic [2:0] REG_RESTART_MODE   = 3'd3;
	localparam logic [2:0] REG_EXPECTED_CODES = 3'd4;
	localparam logic [2:0] REG_EXPECTED_COUNT = 3'd5;

	localparam logic [7:0] RETRY_MAX = 8'hFF;

	typedef struct packed {
		logic [7:0] retries_used;
		logic       command_error;
		logic       hard_kill;
		logic       soft_stop;
		logic       launch;
		logic [2:0] life_state;
	} result_t;

endpackage

`default_nettype wire

// ----- hdl/process_restart_supervisor_fsm.sv -----
// Top level: supervisor state machine for one restartable unit.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tuser: operation; tdata: child_exited, exit_code
//  m_*       out  m_tvalid/m_tready   tdata: life_state, launch, soft_stop, hard_kill,
//                                     command_error, retries_used
//  cfg_*     in   cfg_we              cfg_index, cfg_data
//
// One word is accepted per cycle while s_tready is high; it is held in the input register,
// and its result is then loaded into the result register, from which it can be taken.
// The input register and the state update feed the result register in a single pass.
// Reset puts the block in the stopped state with all counters and marks at zero.
// While m_tready is low the result holds, one more word fits in the input register,
// and then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module process_restart_supervisor_fsm #(
	parameter int NUM_CODES = 4,
	parameter int TIME_BITS = 32
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire  [15:0]      s_tdata,   // child_exited, exit_code, zero fill
	input  wire  [1:0]       s_tuser,   // operation
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [15:0]      m_tdata,   // life_state, launch, soft_stop, hard_kill,
	                                    // command_error, retries_used, zero fill
	input  wire              cfg_we,
	input  wire  [2:0]       cfg_index,
	input  wire  [((NUM_CODES * 8 > 32) ? NUM_CODES * 8 : 32)-1:0] cfg_data
);
	import prs_pkg::*;

	localparam int CODE_W = NUM_CODES * 8;
	localparam int CMP_W  = (TIME_BITS > 32) ? TIME_BITS : 32;

	logic [31:0]          start_window_q;
	logic [31:0]          stop_window_q;
	logic [7:0]           retry_limit_q;
	logic [1:0]           restart_mode_q;
	logic [CODE_W-1:0]    expected_codes_q;
	logic [2:0]           expected_count_q;

	logic                 valid_s1;
	op_t                  op_s1;
	logic                 exited_s1;
	logic [7:0]           code_s1;

	state_t               state_q, state_d;
	logic                 ever_q, ever_d;
	logic                 pending_q, pending_d;
	logic                 seen_q, seen_d;
	logic [7:0]           latched_q, latched_d;
	logic [7:0]           retry_q, retry_d;
	logic [TIME_BITS-1:0] tick_q, tick_d;
	logic [TIME_BITS-1:0] start_mark_q, start_mark_d;
	logic [TIME_BITS-1:0] stop_mark_q, stop_mark_d;

	logic                 out_valid_s2;
	result_t              res_s2, res_d;

	logic                 advance;
	logic [TIME_BITS-1:0] tick_next;
	logic [TIME_BITS-1:0] now;
	logic                 seen_m;
	logic [7:0]           code_m;
	logic                 start_due;
	logic                 stop_due;
	logic                 retries_left;
	logic                 code_expected;
	logic [3:0]           count_eff;
	logic                 p_launch, p_soft, p_kill, p_err;

	assign advance  = valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {1'b0, res_s2};

	assign tick_next = tick_q + TIME_BITS'(1);
	assign now       = (op_s1 == OP_TICK) ? tick_next : tick_q;
	assign seen_m    = seen_q | exited_s1;
	assign code_m    = exited_s1 ? code_s1 : latched_q;
	assign start_due = CMP_W'(tick_next - start_mark_q) > CMP_W'(start_window_q);
	assign stop_due  = CMP_W'(tick_next - stop_mark_q) > CMP_W'(stop_window_q);
	assign retries_left = (retry_limit_q == 8'd0) || (retry_q < retry_limit_q);
	assign count_eff = ({1'b0, expected_count_q} > 4'(NUM_CODES)) ? 4'(NUM_CODES)
	                                                            : {1'b0, expected_count_q};

	always_comb begin
		code_expected = 1'b0;
		for (int i = 0; i < NUM_CODES; i++) begin
			if ((4'(i) < count_eff) && (expected_codes_q[i*8 +: 8] == code_m)) begin
				code_expected = 1'b1;
			end
		end
	end

	function automatic logic [2:0] life_code(input state_t st);
		case (st)
			ST_STARTING: life_code = LS_STARTING;
			ST_RUNNING:  life_code = LS_RUNNING;
			ST_EXITED:   life_code = LS_EXITED;
			ST_STOPPING: life_code = LS_STOPPING;
			ST_BACKOFF:  life_code = LS_BACKOFF;
			default:     life_code = LS_STOPPED;
		endcase
	endfunction

	always_comb begin
		state_d      = state_q;
		ever_d       = ever_q;
		pending_d    = pending_q;
		seen_d       = seen_q;
		latched_d    = latched_q;
		retry_d      = retry_q;
		tick_d       = tick_q;
		start_mark_d = start_mark_q;
		stop_mark_d  = stop_mark_q;
		p_launch     = 1'b0;
		p_soft       = 1'b0;
		p_kill       = 1'b0;
		p_err        = 1'b0;
		case (op_s1)
			OP_TICK: begin
				tick_d    = tick_next;
				seen_d    = seen_m;
				latched_d = code_m;
				case (state_q)
					ST_STARTING: begin
						if (seen_m) begin
							state_d = ST_BACKOFF;
						end else if (start_due) begin
							state_d = ST_RUNNING;
						end
					end
					ST_RUNNING: begin
						if (seen_m) begin
							state_d = ST_EXITED;
						end
					end
					ST_EXITED: begin
						seen_d    = 1'b0;
						latched_d = 8'd0;
						if ((restart_mode_q == MODE_ALWAYS ||
						     (!code_expected && restart_mode_q == MODE_ON_ERROR)) &&
						    retries_left) begin
							state_d      = ST_STARTING;
							start_mark_d = now;
							ever_d       = 1'b1;
							p_launch     = 1'b1;
						end else begin
							state_d = ST_STOPPED;
						end
					end
					ST_STOPPING: begin
						if (seen_m) begin
							state_d = ST_STOPPED;
						end else if (stop_due) begin
							p_kill = 1'b1;
						end
					end
					ST_BACKOFF: begin
						if (retry_q >= retry_limit_q) begin
							state_d = ST_EXITED;
						end else begin
							if (retry_q != RETRY_MAX) begin
								retry_d = retry_q + 8'd1;
							end
							pending_d = 1'b1;
							if (!ever_q) begin
								p_err = 1'b1;
							end else begin
								p_soft      = 1'b1;
								stop_mark_d = now;
								state_d     = ST_STOPPING;
							end
						end
					end
					default: begin
						state_d   = ST_STOPPED;
						seen_d    = 1'b0;
						latched_d = 8'd0;
						if (pending_q || (restart_mode_q == MODE_ALWAYS && retries_left)) begin
							pending_d    = 1'b0;
							state_d      = ST_STARTING;
							start_mark_d = now;
							ever_d       = 1'b1;
							p_launch     = 1'b1;
						end
					end
				endcase
			end
			OP_START: begin
				if (state_q != ST_STOPPED) begin
					p_err = 1'b1;
				end else begin
					state_d      = ST_STARTING;
					start_mark_d = now;
					ever_d       = 1'b1;
					p_launch     = 1'b1;
				end
			end
			default: begin
				if (op_s1 == OP_RESTART) begin
					pending_d = 1'b1;
				end
				if (!ever_q) begin
					p_err = 1'b1;
				end else begin
					p_soft      = 1'b1;
					stop_mark_d = now;
					state_d     = ST_STOPPING;
				end
			end
		endcase
		res_d.life_state    = life_code(state_d);
		res_d.launch        = p_launch;
		res_d.soft_stop     = p_soft;
		res_d.hard_kill     = p_kill;
		res_d.command_error = p_err;
		res_d.retries_used  = retry_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_window_q   <= 32'd1;
			stop_window_q    <= 32'd10;
			retry_limit_q    <= 8'd3;
			restart_mode_q   <= MODE_NEVER;
			expected_codes_q <= '0;
			expected_count_q <= 3'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_WINDOW:   start_window_q   <= cfg_data[31:0];
				REG_STOP_WINDOW:    stop_window_q    <= cfg_data[31:0];
				REG_RETRY_LIMIT:    retry_limit_q    <= cfg_data[7:0];
				REG_RESTART_MODE:   restart_mode_q   <= cfg_data[1:0];
				REG_EXPECTED_CODES: expected_codes_q <= cfg_data[CODE_W-1:0];
				REG_EXPECTED_COUNT: expected_count_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= op_t'(s_tuser);
			exited_s1 <= s_tdata[0];
			code_s1   <= s_tdata[8:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_STOPPED;
			ever_q       <= 1'b0;
			pending_q    <= 1'b0;
			seen_q       <= 1'b0;
			latched_q    <= 8'd0;
			retry_q      <= 8'd0;
			tick_q       <= '0;
			start_mark_q <= '0;
			stop_mark_q  <= '0;
		end else if (advance) begin
			state_q      <= state_d;
			ever_q       <= ever_d;
			pending_q    <= pending_d;
			seen_q       <= seen_d;
			latched_q    <= latched_d;
			retry_q      <= retry_d;
			tick_q       <= tick_d;
			start_mark_q <= start_mark_d;
			stop_mark_q  <= stop_mark_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_s2 && !m_tready))
		else $error("Input stalled although the result register could move.");

	a_launch_enters_starting: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && res_s2.launch) |-> (res_s2.life_state == LS_STARTING))
		else $error("Launch reported outside the starting state.");

	a_kill_while_stopping: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && res_s2.hard_kill) |-> (res_s2.life_state == LS_STOPPING))
		else $error("Hard kill reported outside the stopping state.");

	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> $onehot0({res_s2.launch, res_s2.soft_stop, res_s2.hard_kill,
		                          res_s2.command_error}))
		else $error("More than one pulse in a single result word.");

	a_retry_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (retry_q >= $past(retry_q)))
		else $error("Retry counter decreased.");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the restart supervisor: directed table, then random phases checked by a predictor.
`timescale 1ns / 1ps

module tb;
	import prs_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int PHASE_ITEMS = 285;
	localparam int PHASES = 6;

	typedef struct {
		op_t        op;
		logic       ex;
		logic [7:0] code;
		bit         typed;
		result_t    want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	process_restart_supervisor_fsm dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor configuration and state, at reset values.
	logic [31:0] win_start = 32'd1;
	logic [31:0] win_stop = 32'd10;
	logic [7:0]  lim = 8'd3;
	logic [1:0]  mode = MODE_NEVER;
	logic [31:0] codes = 32'd0;
	logic [2:0]  code_cnt = 3'd1;

	logic [2:0]  cur_state = LS_STOPPED;
	logic        launched = 1'b0;
	logic        rst_pending = 1'b0;
	logic        exit_flag = 1'b0;
	logic [7:0]  held_code = 8'd0;
	logic [7:0]  retry_cnt = 8'd0;
	logic [31:0] tick_now = 32'd0;
	logic [31:0] start_at = 32'd0;
	logic [31:0] stop_at = 32'd0;
	result_t     nxt;

	result_t due_results[$];
	row_t    plan[$];
	int      mismatches = 0;
	int      send_idle = 0;
	int      recv_idle = 0;

	task automatic report(input string what);
		if (mismatches < 100)
			$display("%0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	function automatic result_t res(input logic [2:0] st, input logic l, input logic s,
			input logic k, input logic e, input logic [7:0] r);
		result_t v;
		v.life_state = st;
		v.launch = l;
		v.soft_stop = s;
		v.hard_kill = k;
		v.command_error = e;
		v.retries_used = r;
		return v;
	endfunction

	function automatic bit retries_left();
		return (lim == 8'd0) || (retry_cnt < lim);
	endfunction

	task automatic begin_launch();
		start_at = tick_now;
		launched = 1'b1;
		nxt.launch = 1'b1;
	endtask

	task automatic issue_start();
		if (cur_state != LS_STOPPED) begin
			nxt.command_error = 1'b1;
		end else begin
			cur_state = LS_STARTING;
			begin_launch();
		end
	endtask

	task automatic issue_restart();
		rst_pending = 1'b1;
		if (!launched) begin
			nxt.command_error = 1'b1;
		end else begin
			nxt.soft_stop = 1'b1;
			stop_at = tick_now;
			cur_state = LS_STOPPING;
		end
	endtask

	task automatic advance_supervisor(input op_t op, input logic ex, input logic [7:0] code);
		bit matched;
		int n;
		nxt = '0;
		case (op)
			OP_START: begin
				issue_start();
			end
			OP_STOP: begin
				if (!launched) begin
					nxt.command_error = 1'b1;
				end else begin
					nxt.soft_stop = 1'b1;
					stop_at = tick_now;
					cur_state = LS_STOPPING;
				end
			end
			OP_RESTART: begin
				issue_restart();
			end
			default: begin
				tick_now = tick_now + 32'd1;
				if (ex) begin
					exit_flag = 1'b1;
					held_code = code;
				end
				case (cur_state)
					LS_STARTING: begin
						if (exit_flag)
							cur_state = LS_BACKOFF;
						else if (tick_now - start_at > win_start)
							cur_state = LS_RUNNING;
					end
					LS_RUNNING: begin
						if (exit_flag)
							cur_state = LS_EXITED;
					end
					LS_EXITED: begin
						matched = 1'b0;
						n = (code_cnt > 3'd4) ? 4 : int'(code_cnt);
						for (int i = 0; i < n; i++)
							if (codes[8*i +: 8] == held_code)
								matched = 1'b1;
						held_code = 8'd0;
						exit_flag = 1'b0;
						if ((mode == MODE_ALWAYS || (!matched && mode == MODE_ON_ERROR))
								&& retries_left()) begin
							begin_launch();
							cur_state = LS_STARTING;
						end else begin
							cur_state = LS_STOPPED;
						end
					end
					LS_STOPPING: begin
						if (exit_flag)
							cur_state = LS_STOPPED;
						else if (tick_now - stop_at > win_stop)
							nxt.hard_kill = 1'b1;
					end
					LS_BACKOFF: begin
						if (retry_cnt >= lim) begin
							cur_state = LS_EXITED;
						end else begin
							if (retry_cnt != RETRY_MAX)
								retry_cnt = retry_cnt + 8'd1;
							issue_restart();
						end
					end
					default: begin
						cur_state = LS_STOPPED;
						held_code = 8'd0;
						exit_flag = 1'b0;
						if (rst_pending) begin
							rst_pending = 1'b0;
							issue_start();
						end else if (mode == MODE_ALWAYS && retries_left()) begin
							issue_start();
						end
					end
				endcase
			end
		endcase
		nxt.life_state = cur_state;
		nxt.retries_used = retry_cnt;
	endtask

	task automatic add_row(input op_t op, input logic ex, input logic [7:0] code,
			input bit typed, input result_t want);
		row_t r;
		r.op = op;
		r.ex = ex;
		r.code = code;
		r.typed = typed;
		r.want = want;
		plan = {plan, r};
	endtask

	// Presents one word and returns at the edge where it is taken.
	task automatic send_word(input op_t op, input logic ex, input logic [7:0] code,
			input bit typed, input result_t want);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, code, ex};
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		advance_supervisor(op, ex, code);
		due_results = {due_results, (typed ? want : nxt)};
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_START_WINDOW:   win_start = val;
			REG_STOP_WINDOW:    win_stop = val;
			REG_RETRY_LIMIT:    lim = val[7:0];
			REG_RESTART_MODE:   mode = val[1:0];
			REG_EXPECTED_CODES: codes = val;
			REG_EXPECTED_COUNT: code_cnt = val[2:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic setup_phase(input int p);
		case (p)
			1: begin
				write_reg(REG_START_WINDOW, 32'd0);
				write_reg(REG_STOP_WINDOW, 32'd0);
				write_reg(REG_RETRY_LIMIT, 32'd0);
				write_reg(REG_RESTART_MODE, 32'(MODE_ALWAYS));
				write_reg(REG_EXPECTED_CODES, 32'h00FF7F01);
				write_reg(REG_EXPECTED_COUNT, 32'd4);
			end
			2: begin
				write_reg(REG_START_WINDOW, 32'd2);
				write_reg(REG_STOP_WINDOW, 32'd5);
				write_reg(REG_RETRY_LIMIT, 32'd255);
				write_reg(REG_RESTART_MODE, 32'(MODE_ON_ERROR));
				write_reg(REG_EXPECTED_CODES, 32'h0301FF00);
				write_reg(REG_EXPECTED_COUNT, 32'd2);
			end
			3: begin
				write_reg(REG_START_WINDOW, 32'hFFFFFFFF);
				write_reg(REG_STOP_WINDOW, 32'hFFFFFFFF);
				write_reg(REG_RETRY_LIMIT, 32'd1);
				write_reg(REG_RESTART_MODE, 32'(MODE_ON_ERROR));
				write_reg(REG_EXPECTED_CODES, 32'h11223344);
				write_reg(REG_EXPECTED_COUNT, 32'd7);
			end
			4: begin
				write_reg(REG_START_WINDOW, 32'd1);
				write_reg(REG_STOP_WINDOW, 32'd3);
				write_reg(REG_RETRY_LIMIT, 32'd5);
				write_reg(REG_RESTART_MODE, 32'(MODE_SPARE));
				write_reg(REG_EXPECTED_CODES, 32'hFFFFFFFF);
				write_reg(REG_EXPECTED_COUNT, 32'd0);
			end
			5: begin
				write_reg(REG_START_WINDOW, 32'd3);
				write_reg(REG_STOP_WINDOW, 32'd8);
				write_reg(REG_RETRY_LIMIT, 32'd255);
				write_reg(REG_RESTART_MODE, 32'(MODE_ALWAYS));
				write_reg(REG_EXPECTED_CODES, 32'h80402010);
				write_reg(REG_EXPECTED_COUNT, 32'd4);
			end
			default: begin
				write_reg(REG_START_WINDOW, 32'd0);
				write_reg(REG_STOP_WINDOW, 32'd1);
				write_reg(REG_RETRY_LIMIT, 32'd2);
				write_reg(REG_RESTART_MODE, 32'(MODE_NEVER));
				write_reg(REG_EXPECTED_CODES, 32'h05040302);
				write_reg(REG_EXPECTED_COUNT, 32'd5);
			end
		endcase
		cfg_we <= 1'b0;
	endtask

	// Stops sending, waits, up to a bound, for every expected word, then idles before returning.
	task automatic drain();
		s_tvalid <= 1'b0;
		for (int w = 0; w < 20000 && due_results.size() != 0; w++)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle);

	always @(negedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[14:0]);
			if (due_results.size() == 0) begin
				report($sformatf("unexpected word %h", m_tdata));
			end else begin
				want = due_results.pop_front();
				check_field("life_state", int'(got.life_state), int'(want.life_state));
				check_field("launch", int'(got.launch), int'(want.launch));
				check_field("soft_stop", int'(got.soft_stop), int'(want.soft_stop));
				check_field("hard_kill", int'(got.hard_kill), int'(want.hard_kill));
				check_field("command_error", int'(got.command_error),
					int'(want.command_error));
				check_field("retries_used", int'(got.retries_used),
					int'(want.retries_used));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("process_restart_supervisor_fsm: mismatch");
		$finish;
	end

	initial begin
		int sent;
		int pick;
		op_t op;
		logic ex;
		logic [7:0] code;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 16'd0;
		s_tuser <= OP_TICK;
		m_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_START_WINDOW;
		cfg_data <= 32'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		send_idle = 24;
		recv_idle = 49;

		add_row(OP_TICK, 1'b0, 8'h00, 1, res(LS_STOPPED, 0, 0, 0, 0, 0));
		add_row(OP_STOP, 1'b0, 8'h00, 1, res(LS_STOPPED, 0, 0, 0, 1, 0));
		add_row(OP_RESTART, 1'b1, 8'hFF, 1, res(LS_STOPPED, 0, 0, 0, 1, 0));
		add_row(OP_TICK, 1'b0, 8'h00, 1, res(LS_STARTING, 1, 0, 0, 0, 0));
		add_row(OP_START, 1'b1, 8'h55, 1, res(LS_STARTING, 0, 0, 0, 1, 0));
		add_row(OP_TICK, 1'b0, 8'h00, 0, '0);
		add_row(OP_TICK, 1'b0, 8'hAA, 0, '0);
		add_row(OP_TICK, 1'b1, 8'hFF, 0, '0);
		add_row(OP_TICK, 1'b0, 8'h00, 0, '0);
		add_row(OP_START, 1'b0, 8'h00, 1, res(LS_STARTING, 1, 0, 0, 0, 0));
		add_row(OP_TICK, 1'b1, 8'h00, 0, '0);
		add_row(OP_TICK, 1'b0, 8'h00, 0, '0);
		add_row(OP_TICK, 1'b0, 8'h00, 0, '0);
		add_row(OP_TICK, 1'b0, 8'h00, 0, '0);
		add_row(OP_STOP, 1'b1, 8'h7F, 0, '0);
		add_row(OP_TICK, 1'b1, 8'h80, 0, '0);
		add_row(OP_TICK, 1'b0, 8'h00, 0, '0);
		add_row(OP_RESTART, 1'b0, 8'h01, 0, '0);
		add_row(OP_TICK, 1'b1, 8'h00, 0, '0);
		add_row(OP_TICK, 1'b0, 8'h00, 0, '0);
		add_row(OP_TICK, 1'b1, 8'hFF, 0, '0);
		add_row(OP_TICK, 1'b0, 8'h00, 0, '0);
		add_row(OP_TICK, 1'b0, 8'h00, 0, '0);
		foreach (plan[i])
			send_word(plan[i].op, plan[i].ex, plan[i].code, plan[i].typed, plan[i].want);

		sent = 0;
		for (int p = 1; p <= PHASES; p++) begin
			drain();
			setup_phase(p);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (sent < PHASES * PHASE_ITEMS / 3) begin
					send_idle = 24;
					recv_idle = 49;
				end else if (sent < 2 * PHASES * PHASE_ITEMS / 3) begin
					send_idle = 49;
					recv_idle = 24;
				end else begin
					send_idle = 0;
					recv_idle = 0;
				end
				pick = $urandom_range(99);
				if (pick < 60)
					op = OP_TICK;
				else if (pick < 75)
					op = OP_START;
				else if (pick < 88)
					op = OP_STOP;
				else
					op = OP_RESTART;
				ex = ($urandom_range(99) < 18);
				case ($urandom_range(3))
					0: code = codes[8*$urandom_range(3) +: 8];
					1: code = $urandom_range(1) ? 8'hFF : 8'h00;
					default: code = 8'($urandom_range(255));
				endcase
				send_word(op, ex, code, 0, '0);
				sent++;
			end
		end
		drain();

		while (due_results.size() != 0) begin
			report("expected word never arrived");
			void'(due_results.pop_front());
		end
		if (mismatches == 0)
			$display("process_restart_supervisor_fsm: match");
		else
			$display("process_restart_supervisor_fsm: mismatch");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/prs_pkg.sv
hdl/process_restart_supervisor_fsm.sv
tb/tb.sv
